>>> rtl/lpma_pkg.sv
// Shared types and constants for the load percentage moving-average block.
`default_nettype none
package lpma_pkg;

	// Width of every percentage value (hundredths of a percent, 0..10000)
	localparam int QUO_W  = 14;
	// Step counter for the one-bit-per-cycle multiply and divide
	localparam int STEP_W = 4;
	// Scale factor applied to the busy ticks
	localparam logic [QUO_W-1:0] LOAD_SCALE = 14'd10000;

	// Configuration port
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_SHORT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_MID   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_LONG  = 2'd2;
	localparam logic [CFG_W-1:0] WIN_SHORT_RST = 5'd5;
	localparam logic [CFG_W-1:0] WIN_MID_RST   = 5'd10;
	localparam logic [CFG_W-1:0] WIN_LONG_RST  = 5'd15;

	// Which quotient the shared divider is producing
	typedef enum logic [1:0] {
		SEL_LOAD,
		SEL_SHORT,
		SEL_MID,
		SEL_LONG
	} lpma_sel_t;

	// Controller states
	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_PREP  = 8'b0000_0010,
		S_MUL   = 8'b0000_0100,
		S_DINIT = 8'b0000_1000,
		S_DIV   = 8'b0001_0000,
		S_WRITE = 8'b0010_0000,
		S_WALK  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} lpma_state_t;

	// Controller to datapath
	typedef struct packed {
		logic      capture;
		logic      prep;
		logic      mul_step;
		logic      div_init;
		logic      div_step;
		lpma_sel_t div_sel;
		logic      hist_write;
		logic      walk_step;
		logic      out_load;
	} lpma_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic step_last;
		logic walk_done;
	} lpma_status_t;

endpackage
`default_nettype wire

>>> rtl/load_percent_moving_average.sv
// Top level: busy percentage per sample with three moving averages.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  in      | input     | in_valid / in_stall | idle_ticks, kernel_ticks, user_ticks
//  out     | output    | out_valid/out_stall | load_now, avg_*, *_valid, total_zero
//  cfg     | input     | cfg_wr_en           | cfg_index, cfg_data (window lengths)
//
// The time from one acceptance to the next is set by the shared
// one-bit-per-cycle divider, used four times, the shift-add scaling,
// and the history walk through the single RAM read port.
// Reset needs no clearing pass: an average reaches the output only once every
// entry of its window has been written.
// A stalled result stays in the output register while the next sample is taken.
`default_nettype none
module load_percent_moving_average #(
	parameter int HISTORY_DEPTH = 16,
	parameter int TICK_WIDTH    = 40
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [TICK_WIDTH-1:0]          idle_ticks,
	input  wire logic [TICK_WIDTH-1:0]          kernel_ticks,
	input  wire logic [TICK_WIDTH-1:0]          user_ticks,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [lpma_pkg::QUO_W-1:0]     load_now,
	output logic      [lpma_pkg::QUO_W-1:0]     avg_short,
	output logic      [lpma_pkg::QUO_W-1:0]     avg_mid,
	output logic      [lpma_pkg::QUO_W-1:0]     avg_long,
	output logic                                short_valid,
	output logic                                mid_valid,
	output logic                                long_valid,
	output logic                                total_zero,
	input  wire logic                           cfg_wr_en,
	input  wire logic [lpma_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lpma_pkg::CFG_W-1:0]     cfg_data
);
	import lpma_pkg::*;

	lpma_cmd_t    cmd;
	lpma_status_t sts;

	lpma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpma_dp #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.TICK_WIDTH   (TICK_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.idle_ticks  (idle_ticks),
		.kernel_ticks(kernel_ticks),
		.user_ticks  (user_ticks),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.load_now    (load_now),
		.avg_short   (avg_short),
		.avg_mid     (avg_mid),
		.avg_long    (avg_long),
		.short_valid (short_valid),
		.mid_valid   (mid_valid),
		.long_valid  (long_valid),
		.total_zero  (total_zero)
	);

	// busy share never exceeds 100.00 percent
	a_load_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (load_now <= LOAD_SCALE))
		else $error("load_now above full scale");

	// zero total forces a zero load
	a_tz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && total_zero) |-> (load_now == '0))
		else $error("nonzero load with zero total");

	// the short average without enough history reads as zero
	a_short_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !short_valid) |-> (avg_short == '0))
		else $error("short average not gated");

	// a new result only appears while a sample is in work
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a sample in work");

endmodule
`default_nettype wire

>>> rtl/lpma_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lpma_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/lpma_ctrl.sv
// Sequencing state machine for the load percentage moving-average block.
`default_nettype none
module lpma_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	input  wire lpma_pkg::lpma_status_t sts,
	output lpma_pkg::lpma_cmd_t        cmd
);
	import lpma_pkg::*;

	lpma_state_t state_q, state_d;
	lpma_sel_t   sel_q, sel_d;
	logic        out_valid_q, out_valid_d;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		sel_d       = sel_q;
		out_valid_d = out_valid_q & out_stall;
		cmd         = '0;
		cmd.div_sel = sel_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.step_last) begin
					sel_d   = SEL_LOAD;
					state_d = S_DINIT;
				end
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.step_last) begin
					case (sel_q)
						SEL_LOAD: state_d = S_WRITE;
						SEL_SHORT: begin
							sel_d   = SEL_MID;
							state_d = S_DINIT;
						end
						SEL_MID: begin
							sel_d   = SEL_LONG;
							state_d = S_DINIT;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_WRITE: begin
				cmd.hist_write = 1'b1;
				state_d        = S_WALK;
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_done) begin
					sel_d   = SEL_SHORT;
					state_d = S_DINIT;
				end
			end
			S_DONE: begin
				// wait until the output register is free
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= SEL_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			sel_q       <= sel_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

>>> rtl/lpma_dp.sv
// Datapath: tick arithmetic, shared divider, history ring and window sums.
`default_nettype none
module lpma_dp #(
	parameter int HISTORY_DEPTH = 16,
	parameter int TICK_WIDTH    = 40
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire lpma_pkg::lpma_cmd_t                    cmd,
	output lpma_pkg::lpma_status_t                      sts,
	input  wire logic [TICK_WIDTH-1:0]                  idle_ticks,
	input  wire logic [TICK_WIDTH-1:0]                  kernel_ticks,
	input  wire logic [TICK_WIDTH-1:0]                  user_ticks,
	input  wire logic                                   cfg_wr_en,
	input  wire logic [lpma_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [lpma_pkg::CFG_W-1:0]             cfg_data,
	output logic      [lpma_pkg::QUO_W-1:0]             load_now,
	output logic      [lpma_pkg::QUO_W-1:0]             avg_short,
	output logic      [lpma_pkg::QUO_W-1:0]             avg_mid,
	output logic      [lpma_pkg::QUO_W-1:0]             avg_long,
	output logic                                        short_valid,
	output logic                                        mid_valid,
	output logic                                        long_valid,
	output logic                                        total_zero
);
	import lpma_pkg::*;

	localparam int AW    = $clog2(HISTORY_DEPTH);
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int TOT_W = TICK_WIDTH + 1;
	localparam int NUM_W = TOT_W + QUO_W;
	localparam int SUM_W = QUO_W + CNT_W;
	localparam int WC_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam logic [AW-1:0]    LAST_SLOT = AW'(HISTORY_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);
	localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(HISTORY_DEPTH - 1);
	localparam logic [WC_W-1:0]  DEPTH_WC  = WC_W'(HISTORY_DEPTH);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

	// zero counts as one, anything above the ring depth as the depth
	function automatic logic [CNT_W-1:0] clamp_win(input logic [CFG_W-1:0] w);
		logic [WC_W-1:0] wx;
		wx = WC_W'(w);
		if (w == '0) begin
			return CNT_W'(1);
		end else if (wx > DEPTH_WC) begin
			return DEPTH_CNT;
		end else begin
			return CNT_W'(wx);
		end
	endfunction

	logic [CFG_W-1:0]      win_short_q, win_mid_q, win_long_q;
	logic [CNT_W-1:0]      win_short_c, win_mid_c, win_long_c;
	logic [TICK_WIDTH-1:0] idle_q;
	logic [TOT_W-1:0]      total_q;
	logic                  tz_q;
	logic [NUM_W-1:0]      busy_sh_q, rem_q, dvs_q;
	logic [QUO_W-1:0]      quo_q, quo_next;
	logic                  rem_ge;
	logic [STEP_W-1:0]     step_q;
	logic [QUO_W-1:0]      load_q, avg_short_q, avg_mid_q, avg_long_q;
	logic [AW-1:0]         write_slot_q, rd_addr_q;
	logic [CNT_W-1:0]      sample_count_q, walk_cnt_q, acc_idx_s1;
	logic                  acc_en_s1, walk_issue;
	logic [SUM_W-1:0]      sum_short_q, sum_mid_q, sum_long_q;
	logic [QUO_W-1:0]      ram_rdata;
	logic [NUM_W-1:0]      init_num, init_dvs;
	logic                  v_short, v_mid, v_long;
	logic [QUO_W-1:0]      load_now_q, avg_short_o, avg_mid_o, avg_long_o;
	logic                  short_valid_q, mid_valid_q, long_valid_q, total_zero_q;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_short_q <= WIN_SHORT_RST;
			win_mid_q   <= WIN_MID_RST;
			win_long_q  <= WIN_LONG_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_WIN_SHORT: win_short_q <= cfg_data;
				CFG_WIN_MID:   win_mid_q   <= cfg_data;
				CFG_WIN_LONG:  win_long_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign win_short_c = clamp_win(win_short_q);
	assign win_mid_c   = clamp_win(win_mid_q);
	assign win_long_c  = clamp_win(win_long_q);

	assign v_short = (sample_count_q >= win_short_c);
	assign v_mid   = (sample_count_q >= win_mid_c);
	assign v_long  = (sample_count_q >= win_long_c);

	// divider step and operand selection
	assign rem_ge   = (rem_q >= dvs_q);
	assign quo_next = {quo_q[QUO_W-2:0], rem_ge};

	always_comb begin
		case (cmd.div_sel)
			SEL_LOAD: begin
				init_num = rem_q;
				init_dvs = NUM_W'(total_q);
			end
			SEL_SHORT: begin
				init_num = NUM_W'(sum_short_q);
				init_dvs = NUM_W'(win_short_c);
			end
			SEL_MID: begin
				init_num = NUM_W'(sum_mid_q);
				init_dvs = NUM_W'(win_mid_c);
			end
			default: begin
				init_num = NUM_W'(sum_long_q);
				init_dvs = NUM_W'(win_long_c);
			end
		endcase
	end

	// tick arithmetic, multiply by the scale and the shared restoring divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.prep || cmd.div_init) begin
			step_q <= '0;
		end else if (cmd.mul_step || cmd.div_step) begin
			step_q <= (step_q == LAST_STEP) ? '0 : step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idle_q  <= idle_ticks;
			total_q <= TOT_W'(kernel_ticks) + TOT_W'(user_ticks);
		end
		if (cmd.prep) begin
			tz_q  <= (total_q == '0);
			rem_q <= '0;
			if (total_q != '0 && total_q >= TOT_W'(idle_q)) begin
				busy_sh_q <= NUM_W'(total_q - TOT_W'(idle_q));
			end else begin
				busy_sh_q <= '0;
			end
		end
		if (cmd.mul_step) begin
			if (LOAD_SCALE[step_q]) begin
				rem_q <= rem_q + busy_sh_q;
			end
			busy_sh_q <= busy_sh_q << 1;
		end
		if (cmd.div_init) begin
			rem_q <= init_num;
			dvs_q <= init_dvs << (QUO_W - 1);
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (rem_ge) begin
				rem_q <= rem_q - dvs_q;
			end
			dvs_q <= dvs_q >> 1;
			quo_q <= quo_next;
			if (step_q == LAST_STEP) begin
				case (cmd.div_sel)
					// a zero total divides by zero; the load is defined as zero
					SEL_LOAD:  load_q      <= tz_q ? '0 : quo_next;
					SEL_SHORT: avg_short_q <= quo_next;
					SEL_MID:   avg_mid_q   <= quo_next;
					default:   avg_long_q  <= quo_next;
				endcase
			end
		end
	end

	// history ring
	lpma_ram #(
		.WIDTH(QUO_W),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (cmd.hist_write),
		.waddr(write_slot_q),
		.wdata(load_q),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	// ring pointers and fill count
	assign walk_issue = cmd.walk_step && (walk_cnt_q != DEPTH_CNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q   <= '0;
			sample_count_q <= '0;
			rd_addr_q      <= '0;
			walk_cnt_q     <= '0;
			acc_en_s1      <= 1'b0;
		end else begin
			acc_en_s1 <= walk_issue;
			if (cmd.hist_write) begin
				write_slot_q <= (write_slot_q == LAST_SLOT) ? '0 : write_slot_q + AW'(1);
				if (sample_count_q != DEPTH_CNT) begin
					sample_count_q <= sample_count_q + CNT_W'(1);
				end
				// walk starts at the entry just written and goes backward
				rd_addr_q  <= write_slot_q;
				walk_cnt_q <= '0;
			end else if (walk_issue) begin
				rd_addr_q  <= (rd_addr_q == '0) ? LAST_SLOT : rd_addr_q - AW'(1);
				walk_cnt_q <= walk_cnt_q + CNT_W'(1);
			end
		end
	end

	// window sums, one history entry per cycle
	always_ff @(posedge clk) begin
		acc_idx_s1 <= walk_cnt_q;
		if (cmd.hist_write) begin
			sum_short_q <= '0;
			sum_mid_q   <= '0;
			sum_long_q  <= '0;
		end else if (acc_en_s1) begin
			if (acc_idx_s1 < win_short_c) begin
				sum_short_q <= sum_short_q + SUM_W'(ram_rdata);
			end
			if (acc_idx_s1 < win_mid_c) begin
				sum_mid_q <= sum_mid_q + SUM_W'(ram_rdata);
			end
			if (acc_idx_s1 < win_long_c) begin
				sum_long_q <= sum_long_q + SUM_W'(ram_rdata);
			end
		end
	end

	assign sts.step_last = (step_q == LAST_STEP);
	assign sts.walk_done = acc_en_s1 && (acc_idx_s1 == LAST_IDX);

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			load_now_q    <= load_q;
			avg_short_o   <= v_short ? avg_short_q : '0;
			avg_mid_o     <= v_mid ? avg_mid_q : '0;
			avg_long_o    <= v_long ? avg_long_q : '0;
			short_valid_q <= v_short;
			mid_valid_q   <= v_mid;
			long_valid_q  <= v_long;
			total_zero_q  <= tz_q;
		end
	end

	assign load_now    = load_now_q;
	assign avg_short   = avg_short_o;
	assign avg_mid     = avg_mid_o;
	assign avg_long    = avg_long_o;
	assign short_valid = short_valid_q;
	assign mid_valid   = mid_valid_q;
	assign long_valid  = long_valid_q;
	assign total_zero  = total_zero_q;

endmodule
`default_nettype wire
